FILE: rtl/cmr_pkg.sv
// Shared constants, types and codes for the octant circle rasterizer.
package cmr_pkg;

  localparam int COORD_BITS = 12;
  localparam int STEP_W     = COORD_BITS + 1;
  localparam int DEC_W      = COORD_BITS + 4;
  localparam int PIX_W      = COORD_BITS + 2;

  localparam int IN_DATA_W  = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * PIX_W + 7) / 8) * 8;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int IDX_W      = 3;

  localparam logic [DEC_W-1:0] DEC_INIT     = DEC_W'(3);
  localparam logic [DEC_W-1:0] DEC_INC_SAME = DEC_W'(6);
  localparam logic [DEC_W-1:0] DEC_INC_DIAG = DEC_W'(10);

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_t;

  // One queued run of pixels: a start (five pixels) or an octant step (eight).
  typedef struct packed {
    logic                  is_start;
    logic                  done;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [STEP_W-1:0]     sx;
    logic [STEP_W-1:0]     sy;
  } job_t;

endpackage

FILE: rtl/cmr_front.sv
// Front end: accepts commands, holds the circle state and steps the decision value.
module cmr_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic [cmr_pkg::COORD_BITS-1:0]  in_cx,
  input  logic [cmr_pkg::COORD_BITS-1:0]  in_cy,
  input  logic [cmr_pkg::COORD_BITS-1:0]  in_radius,
  input  logic                            q_full,
  output logic                            push,
  output cmr_pkg::job_t                   push_job
);

  logic [cmr_pkg::COORD_BITS-1:0] cx_r, cx_nxt;
  logic [cmr_pkg::COORD_BITS-1:0] cy_r, cy_nxt;
  logic [cmr_pkg::STEP_W-1:0]     sx_r, sx_nxt;
  logic [cmr_pkg::STEP_W-1:0]     sy_r, sy_nxt;
  logic [cmr_pkg::DEC_W-1:0]      dec_r, dec_nxt;
  logic                           active_r, active_nxt;

  logic                           accept;
  logic [cmr_pkg::DEC_W-1:0]      x_ext, y_ext, step_dec;
  logic [cmr_pkg::STEP_W-1:0]     step_x, step_y;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign x_ext    = cmr_pkg::DEC_W'(sx_r);
  assign y_ext    = cmr_pkg::DEC_W'(sy_r);

  // One octant step: stay on the row while the decision value is not positive.
  always_comb begin
    step_x = sx_r + cmr_pkg::STEP_W'(1);
    if (dec_r[cmr_pkg::DEC_W-1] || (dec_r == '0)) begin
      step_dec = dec_r + (x_ext << 2) + cmr_pkg::DEC_INC_SAME;
      step_y   = sy_r;
    end else begin
      step_dec = dec_r + ((x_ext - y_ext) << 2) + cmr_pkg::DEC_INC_DIAG;
      step_y   = sy_r - cmr_pkg::STEP_W'(1);
    end
  end

  always_comb begin
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    dec_nxt    = dec_r;
    active_nxt = active_r;
    push       = 1'b0;
    push_job   = '{is_start: 1'b0, done: 1'b0, cx: cx_r, cy: cy_r,
                   sx: step_x, sy: step_y};
    if (accept) begin
      if (in_cmd == cmr_pkg::CMD_START) begin
        cx_nxt     = in_cx;
        cy_nxt     = in_cy;
        sx_nxt     = '0;
        sy_nxt     = cmr_pkg::STEP_W'(in_radius);
        dec_nxt    = cmr_pkg::DEC_INIT - (cmr_pkg::DEC_W'(in_radius) << 1);
        active_nxt = 1'b1;
        push       = 1'b1;
        push_job   = '{is_start: 1'b1, done: (in_radius == '0), cx: in_cx, cy: in_cy,
                       sx: '0, sy: cmr_pkg::STEP_W'(in_radius)};
      end else if (active_r) begin
        if (sx_r >= sy_r) begin
          // circle finished: drop the advance and unload
          active_nxt = 1'b0;
        end else begin
          sx_nxt        = step_x;
          sy_nxt        = step_y;
          dec_nxt       = step_dec;
          push          = 1'b1;
          push_job.done = (step_x >= step_y);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      sx_r     <= '0;
      sy_r     <= '0;
      dec_r    <= '0;
      active_r <= 1'b0;
    end else begin
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      sx_r     <= sx_nxt;
      sy_r     <= sy_nxt;
      dec_r    <= dec_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

FILE: rtl/cmr_fifo.sv
// Short job queue between the front end and the pixel emitter.
module cmr_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cmr_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output cmr_pkg::job_t  head_job
);

  cmr_pkg::job_t                mem_r [cmr_pkg::FIFO_DEPTH];
  logic [cmr_pkg::FIFO_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [cmr_pkg::FIFO_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [cmr_pkg::FIFO_CW-1:0]  count_r, count_nxt;

  assign full       = (count_r == cmr_pkg::FIFO_CW'(cmr_pkg::FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + cmr_pkg::FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + cmr_pkg::FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + cmr_pkg::FIFO_CW'(push) - cmr_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: rtl/cmr_back.sv
// Back end: expands each queued job into mirrored pixels, one output word per cycle while out_ready is high.
module cmr_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            head_valid,
  input  cmr_pkg::job_t                   head_job,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cmr_pkg::PIX_W-1:0]       out_px,
  output logic [cmr_pkg::PIX_W-1:0]       out_py,
  output logic                            out_last,
  output logic                            out_done
);

  localparam logic [cmr_pkg::IDX_W-1:0] PIX_CENTER = 3'd0;
  localparam logic [cmr_pkg::IDX_W-1:0] PIX_UP     = 3'd1;
  localparam logic [cmr_pkg::IDX_W-1:0] PIX_DOWN   = 3'd2;
  localparam logic [cmr_pkg::IDX_W-1:0] PIX_RIGHT  = 3'd3;
  localparam logic [cmr_pkg::IDX_W-1:0] PIX_LEFT   = 3'd4;
  localparam logic [cmr_pkg::IDX_W-1:0] LAST_STEP  = 3'd7;

  logic [cmr_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic                       valid_r, valid_nxt;
  logic [cmr_pkg::PIX_W-1:0]  px_r, py_r;
  logic                       last_r, done_r;

  logic                       load, is_last;
  logic [cmr_pkg::STEP_W-1:0] mag_x, mag_y;
  logic                       neg_x, neg_y;
  logic [cmr_pkg::PIX_W-1:0]  cx_ext, cy_ext, mx_ext, my_ext, px_calc, py_calc;

  assign is_last = head_job.is_start ? (idx_r == PIX_LEFT) : (idx_r == LAST_STEP);
  assign load    = head_valid && (!valid_r || out_ready);
  assign pop     = load && is_last;

  // Pick offset magnitudes and signs for the current pixel of the run.
  always_comb begin
    mag_x = '0;
    mag_y = '0;
    neg_x = 1'b0;
    neg_y = 1'b0;
    if (head_job.is_start) begin
      unique case (idx_r)
        PIX_UP: begin
          mag_y = head_job.sy;
        end
        PIX_DOWN: begin
          mag_y = head_job.sy;
          neg_y = 1'b1;
        end
        PIX_RIGHT: begin
          mag_x = head_job.sy;
        end
        PIX_LEFT: begin
          mag_x = head_job.sy;
          neg_x = 1'b1;
        end
        default: begin
          mag_x = '0;
          mag_y = '0;
        end
      endcase
    end else begin
      // upper index bit swaps the axes, next two pick the quadrant
      mag_x = idx_r[2] ? head_job.sy : head_job.sx;
      mag_y = idx_r[2] ? head_job.sx : head_job.sy;
      neg_x = idx_r[1];
      neg_y = idx_r[0];
    end
  end

  assign cx_ext  = cmr_pkg::PIX_W'(head_job.cx);
  assign cy_ext  = cmr_pkg::PIX_W'(head_job.cy);
  assign mx_ext  = cmr_pkg::PIX_W'(mag_x);
  assign my_ext  = cmr_pkg::PIX_W'(mag_y);
  assign px_calc = neg_x ? cx_ext - mx_ext : cx_ext + mx_ext;
  assign py_calc = neg_y ? cy_ext - my_ext : cy_ext + my_ext;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = is_last ? PIX_CENTER : idx_r + cmr_pkg::IDX_W'(1);
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= PIX_CENTER;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      px_r   <= px_calc;
      py_r   <= py_calc;
      last_r <= is_last;
      done_r <= head_job.done;
    end
  end

  assign out_valid = valid_r;
  assign out_px    = px_r;
  assign out_py    = py_r;
  assign out_last  = last_r;
  assign out_done  = done_r;

endmodule

FILE: rtl/circle_rasterizer_octant_top.sv
// Top level of the midpoint circle rasterizer: command front end, job queue, pixel emitter.
// The first pixel word of an item is written into the job queue, then registered in the output
//   stage before it is valid.
// Throughput: one pixel word per cycle while out_tready is high; a start gives 5 words, an
//   advance 8, so a steady stream of advances is limited by the single pixel output port.
// An input item is taken every cycle while the four-entry job queue has room.
// Reset (rst_n low, synchronous) clears the circle state, the queue and the output stage.
module circle_rasterizer_octant_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: center_x, center_y, radius (from bit 0 up), zero padded
  input  logic [cmr_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: cmd (0 start, 1 advance)
  input  logic                              in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata: pixel_x, pixel_y (from bit 0 up), zero padded
  output logic [cmr_pkg::OUT_DATA_W-1:0]    out_tdata,
  // out_tuser: circle_done
  output logic                              out_tuser,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready
);

  localparam int CB = cmr_pkg::COORD_BITS;

  logic                       q_full, q_push, q_pop, q_head_valid;
  cmr_pkg::job_t              q_push_job, q_head_job;
  logic [cmr_pkg::PIX_W-1:0]  pix_x, pix_y;

  // Front end: classify the command, advance the octant state, queue pixel jobs.
  cmr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_cx     (in_tdata[CB-1:0]),
    .in_cy     (in_tdata[2*CB-1:CB]),
    .in_radius (in_tdata[3*CB-1:2*CB]),
    .q_full    (q_full),
    .push      (q_push),
    .push_job  (q_push_job)
  );

  // Decouple command intake from pixel output so each side stalls on its own.
  cmr_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  // Back end: walk the pixels of the head job into the registered output word.
  cmr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_px     (pix_x),
    .out_py     (pix_y),
    .out_last   (out_tlast),
    .out_done   (out_tuser)
  );

  // Pack pixel_x low, pixel_y above it, zero fill to a whole byte.
  assign out_tdata = cmr_pkg::OUT_DATA_W'({pix_y, pix_x});

  // Never write into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job queue written while full");

  // Every accepted start must queue a job.
  a_start_queues: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == cmr_pkg::CMD_START)) |-> q_push)
    else $error("start word accepted without a queued job");

  // No job appears without an accepted input word.
  a_no_invented_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (in_tvalid && in_tready))
    else $error("job queued without an accepted input word");

  // Pop only an entry that is present.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head_valid)
    else $error("job queue popped while empty");

endmodule

FILE: tb/sv/tb_circle_rasterizer_octant_top.sv
// Self-checking testbench for the midpoint circle rasterizer: directed and random circles.
module tb_circle_rasterizer_octant_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 2;
  localparam int RESET_CYCLES = 9;
  localparam int MAX_GAP = 19;
  localparam int WORD_TARGET = 410;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 24;

  // One expected pixel word.
  typedef struct {
    logic [cmr_pkg::PIX_W-1:0] px;
    logic [cmr_pkg::PIX_W-1:0] py;
    logic                      last;
    logic                      done;
  } pixel_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic [cmr_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           in_tuser = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [cmr_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tuser;
  logic                           out_tlast;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;

  // Shadow of the circle state, advanced on every accepted word.
  logic [cmr_pkg::COORD_BITS-1:0] circ_cx;
  logic [cmr_pkg::COORD_BITS-1:0] circ_cy;
  logic [cmr_pkg::STEP_W-1:0]     oct_x;
  logic [cmr_pkg::STEP_W-1:0]     oct_y;
  logic [cmr_pkg::DEC_W-1:0]      oct_dec;
  logic                           circ_live;

  pixel_t pixel_q[$];
  int     errors = 0;
  int     words_sent = 0;
  int     idle_cycles = 0;
  int     rx_wait = 0;
  int     rx_draw;
  bit     rx_burst = 1'b0;
  bit     tx_burst = 1'b0;

  circle_rasterizer_octant_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic pixel_t pixel_at(input int px, input int py);
    pixel_t p;
    p.px   = cmr_pkg::PIX_W'(px);
    p.py   = cmr_pkg::PIX_W'(py);
    p.last = 1'b0;
    p.done = 1'b0;
    return p;
  endfunction

  // Advance the shadow state by one word and queue the pixels it plots.
  task automatic plot_circle_word(input cmr_pkg::cmd_t cmd,
                                  input logic [cmr_pkg::COORD_BITS-1:0] cx,
                                  input logic [cmr_pkg::COORD_BITS-1:0] cy,
                                  input logic [cmr_pkg::COORD_BITS-1:0] r);
    pixel_t run[8];
    int     n;
    int     x;
    int     y;
    int     p;
    int     ox;
    int     oy;
    n = 0;
    if (cmd == cmr_pkg::CMD_START) begin
      // A start abandons whatever circle was running.
      circ_cx   = cx;
      circ_cy   = cy;
      oct_x     = '0;
      oct_y     = cmr_pkg::STEP_W'(r);
      oct_dec   = cmr_pkg::DEC_W'(3 - 2 * int'(r));
      circ_live = 1'b1;
      ox = int'(cx);
      oy = int'(cy);
      y  = int'(r);
      run[0] = pixel_at(ox, oy);
      run[1] = pixel_at(ox, oy + y);
      run[2] = pixel_at(ox, oy - y);
      run[3] = pixel_at(ox + y, oy);
      run[4] = pixel_at(ox - y, oy);
      n = 5;
    end else if (circ_live) begin
      if (oct_x >= oct_y) begin
        // Octant finished: swallow the advance and drop the circle.
        circ_live = 1'b0;
      end else begin
        x = int'(oct_x);
        y = int'(oct_y);
        p = int'($signed(oct_dec));
        if (p <= 0) begin
          p = p + 4 * x + 6;
        end else begin
          p = p + 4 * (x - y) + 10;
          y = y - 1;
        end
        x = x + 1;
        oct_dec = cmr_pkg::DEC_W'(p);
        oct_x   = cmr_pkg::STEP_W'(x);
        oct_y   = cmr_pkg::STEP_W'(y);
        ox = int'(circ_cx);
        oy = int'(circ_cy);
        run[0] = pixel_at(ox + x, oy + y);
        run[1] = pixel_at(ox + x, oy - y);
        run[2] = pixel_at(ox - x, oy + y);
        run[3] = pixel_at(ox - x, oy - y);
        run[4] = pixel_at(ox + y, oy + x);
        run[5] = pixel_at(ox + y, oy - x);
        run[6] = pixel_at(ox - y, oy + x);
        run[7] = pixel_at(ox - y, oy - x);
        n = 8;
      end
    end
    for (int k = 0; k < n; k++) begin
      run[k].done = (oct_x >= oct_y);
      run[k].last = (k == n - 1);
      pixel_q.insert(pixel_q.size(), run[k]);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Drive one word after a random gap (none in burst mode); hold tvalid high across back-to-back words.
  task automatic send_word(input cmr_pkg::cmd_t cmd,
                           input logic [cmr_pkg::COORD_BITS-1:0] cx,
                           input logic [cmr_pkg::COORD_BITS-1:0] cy,
                           input logic [cmr_pkg::COORD_BITS-1:0] r);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= cmr_pkg::IN_DATA_W'({r, cy, cx});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    plot_circle_word(cmd, cx, cy, r);
    words_sent++;
  endtask

  // Advance with random, ignored payload.
  task automatic send_advance();
    send_word(cmr_pkg::CMD_ADVANCE, cmr_pkg::COORD_BITS'($urandom),
              cmr_pkg::COORD_BITS'($urandom), cmr_pkg::COORD_BITS'($urandom));
  endtask

  // Drop valid and hold until every expected pixel has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  // Advances with no circle loaded must plot nothing.
  task automatic test_idle_advance();
    send_advance();
    send_advance();
  endtask

  // Zero radius: five center pixels flagged done, then the next advance
  // drops the circle and the one after finds nothing loaded.
  task automatic test_zero_radius();
    send_word(cmr_pkg::CMD_START, '0, '0, '0);
    send_advance();
    send_advance();
    // Hold off until the block has emptied completely.
    wait_drained();
  endtask

  // Corners of the coordinate space, so pixels reach both ends of the range.
  task automatic test_extreme_centers();
    send_word(cmr_pkg::CMD_START, '1, '1, '1);
    send_advance();
    send_advance();
    send_word(cmr_pkg::CMD_START, '0, '0, '1);
    send_advance();
    send_advance();
    send_word(cmr_pkg::CMD_START, '1, '0, 12'd1);
    send_advance();
  endtask

  // Restart mid-circle, then run a small circle to the end and past it.
  task automatic test_restart_and_complete();
    send_word(cmr_pkg::CMD_START, 12'd2048, 12'd1024, 12'd100);
    send_advance();
    send_word(cmr_pkg::CMD_START, 12'd300, 12'd3000, 12'd3);
    while (circ_live && oct_x < oct_y) send_advance();
    send_advance();
    send_advance();
  endtask

  // Mostly well-formed circles with random content, plus stray advances and
  // back-to-back starts.
  task automatic test_random_circles();
    int kind;
    int extra;
    int steps;
    logic [cmr_pkg::COORD_BITS-1:0] rad;
    while (words_sent < WORD_TARGET) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        if ($urandom_range(0, 9) == 0) rad = cmr_pkg::COORD_BITS'($urandom);
        else rad = cmr_pkg::COORD_BITS'($urandom_range(0, 48));
        send_word(cmr_pkg::CMD_START, cmr_pkg::COORD_BITS'($urandom),
                  cmr_pkg::COORD_BITS'($urandom), rad);
        if (rad <= 48 && $urandom_range(0, 3) != 0) begin
          while (circ_live && oct_x < oct_y) send_advance();
          extra = $urandom_range(0, 2);
          repeat (extra) send_advance();
        end else begin
          steps = $urandom_range(1, 20);
          repeat (steps) send_advance();
        end
      end else if (kind == 8) begin
        extra = $urandom_range(1, 3);
        repeat (extra) send_advance();
      end else begin
        send_word(cmr_pkg::CMD_START, cmr_pkg::COORD_BITS'($urandom),
                  cmr_pkg::COORD_BITS'($urandom), cmr_pkg::COORD_BITS'($urandom));
        send_word(cmr_pkg::CMD_START, cmr_pkg::COORD_BITS'($urandom),
                  cmr_pkg::COORD_BITS'($urandom),
                  cmr_pkg::COORD_BITS'($urandom_range(0, 16)));
      end
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
    tx_burst = 1'b0;
  endtask

  // Result side: check each accepted word, then drop tready for a random stall, or none in burst mode.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait    <= 0;
    end else if (out_tvalid && out_tready) begin
      if (pixel_q.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel word %h", out_tdata));
      end else begin
        if (out_tdata[cmr_pkg::PIX_W-1:0] !== pixel_q[0].px)
          report_mismatch($sformatf("pixel_x %h, want %h",
                                    out_tdata[cmr_pkg::PIX_W-1:0], pixel_q[0].px));
        if (out_tdata[2*cmr_pkg::PIX_W-1:cmr_pkg::PIX_W] !== pixel_q[0].py)
          report_mismatch($sformatf("pixel_y %h, want %h",
                                    out_tdata[2*cmr_pkg::PIX_W-1:cmr_pkg::PIX_W],
                                    pixel_q[0].py));
        if (out_tlast !== pixel_q[0].last)
          report_mismatch($sformatf("last_of_run %b, want %b", out_tlast, pixel_q[0].last));
        if (out_tuser !== pixel_q[0].done)
          report_mismatch($sformatf("circle_done %b, want %b", out_tuser, pixel_q[0].done));
        void'(pixel_q.pop_front());
      end
      rx_draw = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 47) == 0) rx_burst <= !rx_burst;
      if (rx_draw != 0) begin
        out_tready <= 1'b0;
        rx_wait    <= rx_draw - 1;
      end
    end else if (!out_tready) begin
      if (rx_wait == 0) out_tready <= 1'b1;
      else rx_wait <= rx_wait - 1;
    end
  end

  // Watchdog: end the run if neither side moves a word for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("tb_circle_rasterizer_octant_top NOT OK");
          $finish;
        end
      end
    end
  end

  initial begin
    circ_cx   = '0;
    circ_cy   = '0;
    oct_x     = '0;
    oct_y     = '0;
    oct_dec   = '0;
    circ_live = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_advance();
    test_zero_radius();
    test_extreme_centers();
    test_restart_and_complete();
    test_random_circles();

    // Drop valid, drain the pixels, then give stray words time to show up.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_circle_rasterizer_octant_top OK");
    end else begin
      $display("tb_circle_rasterizer_octant_top NOT OK");
    end
    $finish;
  end

endmodule
